FILE: hw/rtl/ihl_pkg.sv
// Shared constants and register codes for the Ising heatbath lattice engine.
package ihl_pkg;

  localparam int MAX_SIDE     = 64;
  localparam int SIDE_W       = $clog2(MAX_SIDE);
  localparam int SIDE_CNT_W   = $clog2(MAX_SIDE + 1);
  localparam int CFG_SIDE_W   = 7;
  localparam int DATA_W       = 32;
  localparam int ADDR_W       = 5;
  localparam int REG_IDX_W    = ADDR_W - 2;
  localparam int OP_W         = 2;
  localparam int NUM_THRESH   = 5;
  localparam int THRESH_IDX_W = 3;
  localparam int THRESH_MID   = 2;
  localparam int MAGN_W       = 14;
  localparam int ENE_W        = 15;

  localparam logic [CFG_SIDE_W-1:0] SIDE_RESET  = CFG_SIDE_W'(64);
  localparam logic [DATA_W-1:0]     THRESH_HALF = 32'h8000_0000;

  localparam logic [OP_W-1:0] OP_INIT    = 2'd0;
  localparam logic [OP_W-1:0] OP_UPDATE  = 2'd1;
  localparam logic [OP_W-1:0] OP_MEASURE = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE    = 2'd3;

  localparam logic [REG_IDX_W-1:0] REG_SIDE     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_HOT      = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_THRESH_0 = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_THRESH_1 = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_THRESH_2 = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_THRESH_3 = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_THRESH_4 = 3'd6;

endpackage

FILE: hw/rtl/ising_heatbath_lattice.sv
// Top level of the two-dimensional Ising lattice engine with heatbath updates.
// The lattice is stored one row per word in a single RAM with one read and one
// write port, and every row carries a valid bit that reset clears, so a row
// never written reads as all spins up and no clearing pass follows reset. An
// initialise transfer reads one row and then writes it, and a heatbath update
// has the read port fetch the row above, the row below and the site's own row
// in turn before the modified row is written back. A measure transfer walks
// the lattice one site per cycle within a row, through a magnetisation and an
// energy accumulator, loading each following row from the read port. Input is
// taken only while the sequencer is idle, and a result is held in the output
// register until its transfer.
module ising_heatbath_lattice (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic [ihl_pkg::ADDR_W-1:0]              paddr,
  input  logic [ihl_pkg::DATA_W-1:0]              pwdata,
  output logic [ihl_pkg::DATA_W-1:0]              prdata,
  output logic                                    pready,
  input  logic                                    item_valid,
  output logic                                    item_ready,
  input  logic [ihl_pkg::OP_W-1:0]                op,
  input  logic [ihl_pkg::DATA_W-1:0]              rand_fraction,
  output logic                                    result_valid,
  input  logic                                    result_ready,
  output logic [ihl_pkg::SIDE_W-1:0]              site_row,
  output logic [ihl_pkg::SIDE_W-1:0]              site_col,
  output logic                                    spin_down,
  output logic                                    sweep_end,
  output logic signed [ihl_pkg::MAGN_W-1:0]       magnet_sum,
  output logic signed [ihl_pkg::ENE_W-1:0]        energy_sum
);

  import ihl_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b00_0000_0001,
    S_RD_UP  = 10'b00_0000_0010,
    S_RD_DN  = 10'b00_0000_0100,
    S_RD_ROW = 10'b00_0000_1000,
    S_WR     = 10'b00_0001_0000,
    S_M_RD0  = 10'b00_0010_0000,
    S_M_LD0  = 10'b00_0100_0000,
    S_M_LDN  = 10'b00_1000_0000,
    S_M_COL  = 10'b01_0000_0000,
    S_M_DONE = 10'b10_0000_0000
  } state_t;

  state_t state, state_next;

  logic [CFG_SIDE_W-1:0] lattice_side;
  logic                  start_hot;
  logic [DATA_W-1:0]     flip_thresh [NUM_THRESH];

  logic [SIDE_CNT_W-1:0] side;
  logic [SIDE_W-1:0]     side_m1;
  logic                  cfg_we;
  logic [REG_IDX_W-1:0]  reg_idx;

  logic [SIDE_W-1:0]     row_ptr, col_ptr;
  logic [MAX_SIDE-1:0]   row_valid;
  logic                  rvalid_q;
  logic                  ptr_oob;
  logic                  item_fire;
  logic                  out_free;
  logic                  wr_en;
  logic                  meas_done;

  logic [OP_W-1:0]       op_q;
  logic [DATA_W-1:0]     rand_q;
  logic                  up_bit, dn_bit;

  logic [SIDE_W-1:0]     rd_addr;
  logic [MAX_SIDE-1:0]   rd_data;
  logic [MAX_SIDE-1:0]   row_data;
  logic [MAX_SIDE-1:0]   row_new;
  logic                  left_bit, right_bit;
  logic [THRESH_IDX_W-1:0] downs;
  logic [THRESH_IDX_W-1:0] thresh_idx;
  logic                  new_down;

  logic [SIDE_W-1:0]     meas_row, meas_col;
  logic [MAX_SIDE-1:0]   first_row, cur_row, nxt_row;
  logic signed [MAGN_W-1:0] magn_acc, magn_delta;
  logic signed [ENE_W-1:0]  ene_acc, ene_delta;
  logic                  sp_bit, sp_right, sp_below;

  function automatic logic [SIDE_W-1:0] wrap_fwd(input logic [SIDE_W-1:0] x,
                                                 input logic [SIDE_CNT_W-1:0] s);
    logic [SIDE_CNT_W-1:0] x1;
    x1 = SIDE_CNT_W'(x) + SIDE_CNT_W'(1);
    return (x1 >= s) ? '0 : SIDE_W'(x1);
  endfunction

  function automatic logic [SIDE_W-1:0] wrap_bwd(input logic [SIDE_W-1:0] x,
                                                 input logic [SIDE_CNT_W-1:0] s);
    return (x == '0) ? SIDE_W'(s - SIDE_CNT_W'(1)) : x - SIDE_W'(1);
  endfunction

  always_comb begin
    if (lattice_side < CFG_SIDE_W'(2)) begin
      side = SIDE_CNT_W'(2);
    end else if (int'(lattice_side) > MAX_SIDE) begin
      side = SIDE_CNT_W'(MAX_SIDE);
    end else begin
      side = SIDE_CNT_W'(lattice_side);
    end
  end

  assign side_m1 = SIDE_W'(side - SIDE_CNT_W'(1));

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign reg_idx = paddr[ADDR_W-1:2];

  always_comb begin
    case (reg_idx)
      REG_SIDE:     prdata = DATA_W'(lattice_side);
      REG_HOT:      prdata = DATA_W'(start_hot);
      REG_THRESH_0: prdata = flip_thresh[0];
      REG_THRESH_1: prdata = flip_thresh[1];
      REG_THRESH_2: prdata = flip_thresh[2];
      REG_THRESH_3: prdata = flip_thresh[3];
      REG_THRESH_4: prdata = flip_thresh[4];
      default:      prdata = '0;
    endcase
  end

  assign item_ready = (state == S_IDLE);
  assign item_fire  = item_valid && item_ready;
  assign out_free   = !result_valid || result_ready;
  assign wr_en      = (state == S_WR) && out_free;
  assign meas_done  = (state == S_M_DONE) && out_free;
  assign ptr_oob    = (SIDE_CNT_W'(row_ptr) >= side) || (SIDE_CNT_W'(col_ptr) >= side);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          case (op)
            OP_INIT:    state_next = S_RD_ROW;
            OP_UPDATE:  state_next = S_RD_UP;
            OP_MEASURE: state_next = S_M_RD0;
            default:    state_next = S_IDLE;
          endcase
        end
      end
      S_RD_UP:  state_next = S_RD_DN;
      S_RD_DN:  state_next = S_RD_ROW;
      S_RD_ROW: state_next = S_WR;
      S_WR: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      S_M_RD0:  state_next = S_M_LD0;
      S_M_LD0:  state_next = S_M_LDN;
      S_M_LDN:  state_next = S_M_COL;
      S_M_COL: begin
        if (meas_col == side_m1) begin
          state_next = (meas_row == side_m1) ? S_M_DONE : S_M_LDN;
        end
      end
      S_M_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    case (state)
      S_RD_UP:  rd_addr = wrap_bwd(row_ptr, side);
      S_RD_DN:  rd_addr = wrap_fwd(row_ptr, side);
      S_M_RD0:  rd_addr = '0;
      S_M_LD0:  rd_addr = SIDE_W'(1);
      S_M_COL:  rd_addr = meas_row + SIDE_W'(2);
      default:  rd_addr = row_ptr;
    endcase
  end

  ihl_ram #(
    .WIDTH (MAX_SIDE),
    .DEPTH (MAX_SIDE)
  ) u_rows (
    .clk   (clk),
    .we    (wr_en),
    .waddr (row_ptr),
    .wdata (row_new),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  assign row_data = rvalid_q ? rd_data : '0;

  assign left_bit   = row_data[wrap_bwd(col_ptr, side)];
  assign right_bit  = row_data[wrap_fwd(col_ptr, side)];
  assign downs      = THRESH_IDX_W'(up_bit) + THRESH_IDX_W'(dn_bit)
                    + THRESH_IDX_W'(left_bit) + THRESH_IDX_W'(right_bit);
  assign thresh_idx = THRESH_IDX_W'(NUM_THRESH - 1) - downs;
  assign new_down   = (op_q == OP_INIT) ? (start_hot && rand_q[DATA_W-1])
                                        : (rand_q < flip_thresh[thresh_idx]);

  always_comb begin
    row_new          = row_data;
    row_new[col_ptr] = new_down;
  end

  assign sp_bit     = cur_row[meas_col];
  assign sp_right   = cur_row[wrap_fwd(meas_col, side)];
  assign sp_below   = nxt_row[meas_col];
  assign magn_delta = MAGN_W'(1) - MAGN_W'({sp_bit, 1'b0});
  assign ene_delta  = ENE_W'({(sp_bit == sp_below), 1'b0})
                    + ENE_W'({(sp_bit == sp_right), 1'b0}) - ENE_W'(2);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      lattice_side <= SIDE_RESET;
      start_hot    <= 1'b0;
      for (int i = 0; i < NUM_THRESH; i++) begin
        flip_thresh[i] <= (i == THRESH_MID) ? THRESH_HALF : '0;
      end
      row_ptr      <= '0;
      col_ptr      <= '0;
      row_valid    <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (reg_idx)
          REG_SIDE:     lattice_side   <= pwdata[CFG_SIDE_W-1:0];
          REG_HOT:      start_hot      <= pwdata[0];
          REG_THRESH_0: flip_thresh[0] <= pwdata;
          REG_THRESH_1: flip_thresh[1] <= pwdata;
          REG_THRESH_2: flip_thresh[2] <= pwdata;
          REG_THRESH_3: flip_thresh[3] <= pwdata;
          REG_THRESH_4: flip_thresh[4] <= pwdata;
          default: ;
        endcase
      end
      if (wr_en || meas_done) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      if (item_fire && (op == OP_INIT || op == OP_UPDATE) && ptr_oob) begin
        row_ptr <= '0;
        col_ptr <= '0;
      end
      if (wr_en) begin
        row_valid[row_ptr] <= 1'b1;
        if (col_ptr == side_m1) begin
          col_ptr <= '0;
          row_ptr <= (row_ptr == side_m1) ? '0 : row_ptr + SIDE_W'(1);
        end else begin
          col_ptr <= col_ptr + SIDE_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    rvalid_q <= row_valid[rd_addr];
    if (item_fire) begin
      op_q   <= op;
      rand_q <= rand_fraction;
    end
    case (state)
      S_RD_DN:  up_bit <= row_data[col_ptr];
      S_RD_ROW: dn_bit <= row_data[col_ptr];
      S_M_LD0: begin
        first_row <= row_data;
        cur_row   <= row_data;
        meas_row  <= '0;
        magn_acc  <= '0;
        ene_acc   <= '0;
      end
      S_M_LDN: begin
        nxt_row  <= (meas_row == side_m1) ? first_row : row_data;
        meas_col <= '0;
      end
      S_M_COL: begin
        magn_acc <= magn_acc + magn_delta;
        ene_acc  <= ene_acc + ene_delta;
        meas_col <= meas_col + SIDE_W'(1);
        if (meas_col == side_m1) begin
          cur_row  <= nxt_row;
          meas_row <= meas_row + SIDE_W'(1);
        end
      end
      default: ;
    endcase
    if (wr_en) begin
      site_row   <= row_ptr;
      site_col   <= col_ptr;
      spin_down  <= new_down;
      sweep_end  <= (row_ptr == side_m1) && (col_ptr == side_m1);
      magnet_sum <= '0;
      energy_sum <= '0;
    end else if (meas_done) begin
      site_row   <= '0;
      site_col   <= '0;
      spin_down  <= 1'b0;
      sweep_end  <= 1'b0;
      magnet_sum <= magn_acc;
      energy_sum <= ene_acc;
    end
  end

endmodule

FILE: hw/rtl/ihl_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module ihl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/ihl_checker.sv
// Port-level checker for the Ising heatbath lattice engine and its bind.
module ihl_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                item_valid,
  input logic                                item_ready,
  input logic [ihl_pkg::OP_W-1:0]            op,
  input logic                                result_valid,
  input logic                                result_ready,
  input logic [ihl_pkg::SIDE_W-1:0]          site_row,
  input logic [ihl_pkg::SIDE_W-1:0]          site_col,
  input logic                                spin_down,
  input logic                                sweep_end,
  input logic signed [ihl_pkg::MAGN_W-1:0]   magnet_sum,
  input logic signed [ihl_pkg::ENE_W-1:0]    energy_sum
);

  import ihl_pkg::*;

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(site_row)
      && $stable(site_col) && $stable(spin_down) && $stable(magnet_sum)
      && $stable(energy_sum))
    else $error("Result changed while its transfer was stalled.");

  a_busy_after_op: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && op != OP_NONE |=> !item_ready)
    else $error("Input was ready again right after an operation started.");

  a_last_site_diag: assert property (@(posedge clk) disable iff (rst)
    result_valid && sweep_end |-> site_row == site_col)
    else $error("End of sweep reported away from the last diagonal site.");

  a_measure_clean: assert property (@(posedge clk) disable iff (rst)
    result_valid && (magnet_sum != 0 || energy_sum != 0)
      |-> site_row == 0 && site_col == 0 && !spin_down && !sweep_end)
    else $error("Measure result carried site fields.");

  a_energy_even: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !energy_sum[0])
    else $error("Bond energy sum is odd.");

endmodule

bind ising_heatbath_lattice ihl_checker u_ihl_checker (.*);

FILE: bench/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for the Ising heatbath lattice engine: directed rows, then random phases.
module testbench;
  import ihl_pkg::*;

  localparam int RANDOM_ITEMS = 700;
  localparam int STALL_LIMIT  = 20000;

  typedef struct packed {
    logic [SIDE_W-1:0] row;
    logic [SIDE_W-1:0] col;
    logic              down;
    logic              last;
    logic [MAGN_W-1:0] magn;
    logic [ENE_W-1:0]  ene;
  } site_report_t;

  typedef struct packed {
    logic                 is_cfg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic [OP_W-1:0]      code;
    logic [DATA_W-1:0]    value;
    logic                 known;
    site_report_t         want;
  } plan_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [ADDR_W-1:0]    paddr = '0;
  logic [DATA_W-1:0]    pwdata = '0;
  logic [DATA_W-1:0]    prdata;
  logic                 pready;
  logic                 item_valid = 1'b0;
  logic                 item_ready;
  logic [OP_W-1:0]      op = OP_INIT;
  logic [DATA_W-1:0]    rand_fraction = '0;
  logic                 result_valid;
  logic                 result_ready = 1'b0;
  logic [SIDE_W-1:0]    site_row;
  logic [SIDE_W-1:0]    site_col;
  logic                 spin_down;
  logic                 sweep_end;
  logic signed [MAGN_W-1:0] magnet_sum;
  logic signed [ENE_W-1:0]  energy_sum;

  logic [MAX_SIDE*MAX_SIDE-1:0] down_map = '0;
  logic [CFG_SIDE_W-1:0]        side_reg = SIDE_RESET;
  logic                         hot_reg = 1'b0;
  logic [DATA_W-1:0]            flip_level [NUM_THRESH] = '{0, 0, THRESH_HALF, 0, 0};
  int                           ptr_row = 0;
  int                           ptr_col = 0;

  site_report_t reports_due[$];
  plan_row_t    directed[$];
  int           errors = 0;
  int           counted = 0;
  bit           calm = 1'b0;

  ising_heatbath_lattice i_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .item_valid(item_valid), .item_ready(item_ready), .op(op), .rand_fraction(rand_fraction),
    .result_valid(result_valid), .result_ready(result_ready),
    .site_row(site_row), .site_col(site_col), .spin_down(spin_down), .sweep_end(sweep_end),
    .magnet_sum(magnet_sum), .energy_sum(energy_sum)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int side_in_use();
    if (side_reg < 2) return 2;
    if (side_reg > MAX_SIDE) return MAX_SIDE;
    return int'(side_reg);
  endfunction

  function automatic int spin_of(int r, int c);
    return down_map[r*MAX_SIDE + c] ? -1 : 1;
  endfunction

  function automatic int step_fwd(int x, int s);
    return (x + 1 >= s) ? 0 : x + 1;
  endfunction

  function automatic bit heatbath_step(input logic [OP_W-1:0] code,
                                       input logic [DATA_W-1:0] frac,
                                       output site_report_t rep);
    int s, r, c, sp, sum, magn, ene;
    logic dn;
    rep = '0;
    s = side_in_use();
    if (code == OP_NONE) return 1'b0;
    if (code == OP_MEASURE) begin
      magn = 0;
      ene = 0;
      for (r = 0; r < s; r++) begin
        for (c = 0; c < s; c++) begin
          sp = spin_of(r, c);
          magn += sp;
          ene += sp * (spin_of(step_fwd(r, s), c) + spin_of(r, step_fwd(c, s)));
        end
      end
      rep.magn = MAGN_W'(magn);
      rep.ene = ENE_W'(ene);
      return 1'b1;
    end
    if (ptr_row >= s || ptr_col >= s) begin
      ptr_row = 0;
      ptr_col = 0;
    end
    r = ptr_row;
    c = ptr_col;
    if (code == OP_INIT) begin
      dn = hot_reg && (frac >= THRESH_HALF);
    end else begin
      sum = spin_of(step_fwd(r, s), c) + spin_of((r == 0) ? s - 1 : r - 1, c)
          + spin_of(r, step_fwd(c, s)) + spin_of(r, (c == 0) ? s - 1 : c - 1);
      dn = frac < flip_level[sum / 2 + THRESH_MID];
    end
    down_map[r*MAX_SIDE + c] = dn;
    rep.row = SIDE_W'(r);
    rep.col = SIDE_W'(c);
    rep.down = dn;
    rep.last = (r == s - 1) && (c == s - 1);
    if (c + 1 >= s) begin
      ptr_col = 0;
      ptr_row = step_fwd(r, s);
    end else begin
      ptr_col = c + 1;
    end
    return 1'b1;
  endfunction

  function automatic logic [DATA_W-1:0] pick_fraction();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return THRESH_HALF - DATA_W'($urandom_range(0, 1));
      default: return $urandom();
    endcase
  endfunction

  function automatic int pause_len();
    return calm ? 0 : int'($urandom_range(0, 4));
  endfunction

  function automatic plan_row_t reg_row(logic [REG_IDX_W-1:0] idx, logic [DATA_W-1:0] v);
    plan_row_t p;
    p = '0;
    p.is_cfg = 1'b1;
    p.reg_idx = idx;
    p.value = v;
    return p;
  endfunction

  function automatic plan_row_t op_row(logic [OP_W-1:0] code, logic [DATA_W-1:0] frac);
    plan_row_t p;
    p = '0;
    p.code = code;
    p.value = frac;
    return p;
  endfunction

  function automatic plan_row_t known_row(logic [OP_W-1:0] code, logic [DATA_W-1:0] frac,
                                          int r, int c, bit dn, bit lst, int magn, int ene);
    plan_row_t p;
    p = op_row(code, frac);
    p.known = 1'b1;
    p.want.row = SIDE_W'(r);
    p.want.col = SIDE_W'(c);
    p.want.down = dn;
    p.want.last = lst;
    p.want.magn = MAGN_W'(magn);
    p.want.ene = ENE_W'(ene);
    return p;
  endfunction

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_SIDE: side_reg = v[CFG_SIDE_W-1:0];
      REG_HOT: hot_reg = v[0];
      default: flip_level[idx - REG_THRESH_0] = v;
    endcase
  endtask

  task automatic push_item(input logic [OP_W-1:0] code, input logic [DATA_W-1:0] frac,
                           input logic known, input site_report_t want);
    int gap;
    site_report_t rep;
    gap = pause_len();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    op <= code;
    rand_fraction <= frac;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    if (heatbath_step(code, frac, rep)) reports_due.push_back(known ? want : rep);
    if (code != OP_NONE) counted++;
  endtask

  task automatic settle();
    item_valid <= 1'b0;
    while (reports_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  initial begin
    int gap;
    site_report_t want;
    forever begin
      gap = pause_len();
      if (gap > 0) begin
        result_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      result_ready <= 1'b1;
      @(posedge clk);
      while (!result_valid) @(posedge clk);
      if (reports_due.size() == 0) begin
        $error("result transfer with nothing outstanding");
        errors++;
      end else begin
        want = reports_due.pop_front();
        if (site_row !== want.row) begin
          $error("site_row: expected %0d, got %0d", want.row, site_row);
          errors++;
        end
        if (site_col !== want.col) begin
          $error("site_col: expected %0d, got %0d", want.col, site_col);
          errors++;
        end
        if (spin_down !== want.down) begin
          $error("spin_down: expected %0d, got %0d", want.down, spin_down);
          errors++;
        end
        if (sweep_end !== want.last) begin
          $error("sweep_end: expected %0d, got %0d", want.last, sweep_end);
          errors++;
        end
        if (magnet_sum !== want.magn) begin
          $error("magnet_sum: expected %0d, got %0d", $signed(want.magn), magnet_sum);
          errors++;
        end
        if (energy_sum !== want.ene) begin
          $error("energy_sum: expected %0d, got %0d", $signed(want.ene), energy_sum);
          errors++;
        end
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((item_valid && item_ready) || (result_valid && result_ready)) quiet = 0;
      else quiet++;
    end
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    bit apb_busy;
    int pick, sv, s, len, i, t;
    logic [DATA_W-1:0] lvl;
    logic [OP_W-1:0] code;

    // A fresh lattice is all up, so the first measure sees full magnetization and energy.
    directed.push_back(known_row(OP_MEASURE, 32'h0, 0, 0, 0, 0, 4096, 8192));
    directed.push_back(known_row(OP_INIT, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0));
    directed.push_back(known_row(OP_UPDATE, 32'h0, 0, 1, 0, 0, 0, 0));
    directed.push_back(op_row(OP_NONE, 32'hFFFF_FFFF));
    directed.push_back(op_row(OP_UPDATE, 32'h7FFF_FFFF));
    // Shrinking to side 2 puts the pointer outside, so the sweep restarts at the origin.
    directed.push_back(reg_row(REG_SIDE, 32'd2));
    directed.push_back(reg_row(REG_HOT, 32'd1));
    directed.push_back(reg_row(REG_THRESH_0, 32'hFFFF_FFFF));
    directed.push_back(reg_row(REG_THRESH_4, 32'hFFFF_FFFF));
    directed.push_back(known_row(OP_INIT, 32'h7FFF_FFFF, 0, 0, 0, 0, 0, 0));
    directed.push_back(known_row(OP_INIT, 32'h8000_0000, 0, 1, 1, 0, 0, 0));
    directed.push_back(known_row(OP_INIT, 32'h0, 1, 0, 0, 0, 0, 0));
    directed.push_back(known_row(OP_INIT, 32'hFFFF_FFFF, 1, 1, 1, 1, 0, 0));
    directed.push_back(op_row(OP_MEASURE, 32'h1234_5678));
    directed.push_back(op_row(OP_UPDATE, 32'h0));
    directed.push_back(op_row(OP_UPDATE, 32'hFFFF_FFFE));
    directed.push_back(op_row(OP_UPDATE, 32'h8000_0000));
    directed.push_back(op_row(OP_UPDATE, 32'h0));
    directed.push_back(op_row(OP_MEASURE, 32'hFFFF_FFFF));
    // Side 0 is clamped up to 2, side 127 down to the full lattice.
    directed.push_back(reg_row(REG_SIDE, 32'd0));
    directed.push_back(reg_row(REG_HOT, 32'd0));
    directed.push_back(reg_row(REG_THRESH_1, 32'h8000_0000));
    directed.push_back(reg_row(REG_THRESH_2, 32'hFFFF_FFFF));
    directed.push_back(reg_row(REG_THRESH_3, 32'h0000_0001));
    directed.push_back(op_row(OP_UPDATE, 32'h0));
    directed.push_back(op_row(OP_INIT, 32'hFFFF_FFFF));
    directed.push_back(op_row(OP_UPDATE, 32'h0));
    directed.push_back(op_row(OP_MEASURE, 32'h0));
    directed.push_back(reg_row(REG_SIDE, 32'd127));
    directed.push_back(reg_row(REG_THRESH_2, 32'h0));
    directed.push_back(op_row(OP_UPDATE, 32'hFFFF_FFFF));
    directed.push_back(op_row(OP_MEASURE, 32'h0));
    directed.push_back(op_row(OP_NONE, 32'h0));

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    apb_busy = 1'b0;
    foreach (directed[k]) begin
      if (directed[k].is_cfg) begin
        if (!apb_busy) settle();
        write_reg(directed[k].reg_idx, directed[k].value);
        apb_busy = 1'b1;
      end else begin
        if (apb_busy) begin
          psel <= 1'b0;
          penable <= 1'b0;
          apb_busy = 1'b0;
        end
        push_item(directed[k].code, directed[k].value, directed[k].known, directed[k].want);
      end
    end

    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      settle();
      pick = $urandom_range(0, 99);
      if (pick < 65) sv = $urandom_range(2, 6);
      else if (pick < 80) sv = $urandom_range(7, 12);
      else if (pick < 88) sv = $urandom_range(0, 1);
      else if (pick < 93) sv = $urandom_range(13, 40);
      else sv = $urandom_range(41, 127);
      write_reg(REG_SIDE, DATA_W'(sv));
      write_reg(REG_HOT, DATA_W'($urandom_range(0, 1)));
      for (t = 0; t < NUM_THRESH; t++) begin
        case ($urandom_range(0, 9))
          0, 1: lvl = '0;
          2, 3: lvl = '1;
          4: lvl = THRESH_HALF;
          default: lvl = $urandom();
        endcase
        write_reg(REG_IDX_W'(REG_THRESH_0 + t), lvl);
      end
      psel <= 1'b0;
      penable <= 1'b0;
      calm = ($urandom_range(0, 3) == 0);
      s = side_in_use();
      if (s <= 12) begin
        // Usually a full sweep of initializations, then heatbath sweeps with measures mixed in.
        if ($urandom_range(0, 2) != 0) begin
          for (i = 0; i < s * s; i++) begin
            code = ($urandom_range(0, 19) == 0) ? OP_NONE : OP_INIT;
            push_item(code, pick_fraction(), 1'b0, '0);
          end
        end
        len = $urandom_range(20, 3 * s * s + 20);
        if (len > 150) len = 150;
        for (i = 0; i < len; i++) begin
          pick = $urandom_range(0, 99);
          if (pick < 8) code = OP_MEASURE;
          else if (pick < 11) code = OP_NONE;
          else if (pick < 15) code = OP_INIT;
          else code = OP_UPDATE;
          push_item(code, pick_fraction(), 1'b0, '0);
        end
      end else begin
        // Large lattices measure slowly, so only two measures per phase.
        for (i = 0; i < 30; i++) begin
          pick = $urandom_range(0, 99);
          if (i == 10 || i == 25) code = OP_MEASURE;
          else if (pick < 5) code = OP_NONE;
          else if (pick < 15) code = OP_INIT;
          else code = OP_UPDATE;
          push_item(code, pick_fraction(), 1'b0, '0);
        end
      end
    end

    settle();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/ihl_pkg.sv
hw/rtl/ihl_ram.sv
hw/rtl/ising_heatbath_lattice.sv
hw/rtl/ihl_checker.sv
bench/testbench.sv
